>>> rtl/core/peu_pkg.sv
// peu_pkg: shared types, register indexes and the saturation helper
// for the particle step pipeline; no dependencies
package peu_pkg;

    localparam int unsigned DIV_STAGES = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    // kinematics takes four stages, the age fraction path takes the divider
    // plus three blend stages; the difference is made up by a delay line
    localparam int unsigned KIN_DLY    = DIV_STAGES - 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP   = 3'd0,
        CFG_GRAVITY_X   = 3'd1,
        CFG_GRAVITY_Y   = 3'd2,
        CFG_GRAVITY_Z   = 3'd3,
        CFG_START_COLOR = 3'd4,
        CFG_END_COLOR   = 3'd5,
        CFG_START_SIZE  = 3'd6,
        CFG_END_SIZE    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               alive_in;
        logic signed [31:0] life_in;
        logic [30:0]        initial_life;
        logic signed [31:0] vel_x_in;
        logic signed [31:0] vel_y_in;
        logic signed [31:0] vel_z_in;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] pos_z_in;
    } t_in_item;

    typedef struct packed {
        logic               alive_out;
        logic signed [31:0] life_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic signed [31:0] vel_z_out;
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] pos_z_out;
        logic [63:0]        color_out;
        logic [15:0]        size_out;
    } t_out_item;

    // clamp a wide signed sum into q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -49'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/peu_kin.sv
// peu_kin: four-stage euler update of velocity and position
// depends on peu_pkg for sat32
module peu_kin (
    input  logic               i_clk,
    input  logic [30:0]        i_time_step,
    input  logic signed [31:0] i_grav [3],
    input  logic signed [31:0] i_vel  [3],
    input  logic signed [31:0] i_pos  [3],
    output logic signed [31:0] o_vel  [3],
    output logic signed [31:0] o_pos  [3]
);

    logic signed [63:0] r_gprod [3];
    logic signed [31:0] r_pos1  [3];
    logic signed [31:0] r_vel1  [3];
    logic signed [31:0] r_vel2  [3];
    logic signed [31:0] r_pos2  [3];
    logic signed [63:0] r_vprod [3];
    logic signed [31:0] r_vel3  [3];
    logic signed [31:0] r_pos3  [3];
    logic signed [31:0] r_vel4  [3];
    logic signed [31:0] r_pos4  [3];
    logic signed [31:0] w_ts;

    assign w_ts = $signed({1'b0, i_time_step});

    for (genvar a = 0; a < 3; a++) begin : g_axis
        always_ff @(posedge i_clk) begin
            // gravity times step
            r_gprod[a] <= i_grav[a] * w_ts;
            r_pos1[a]  <= i_pos[a];
            r_vel1[a]  <= i_vel[a];
            // velocity add, floor by arithmetic shift
            r_vel2[a]  <= peu_pkg::sat32({{17{r_vel1[a][31]}}, r_vel1[a]}
                                         + {{2{r_gprod[a][62]}}, r_gprod[a][62:16]});
            r_pos2[a]  <= r_pos1[a];
            // new velocity times step
            r_vprod[a] <= r_vel2[a] * w_ts;
            r_vel3[a]  <= r_vel2[a];
            r_pos3[a]  <= r_pos2[a];
            r_pos4[a]  <= peu_pkg::sat32({{17{r_pos3[a][31]}}, r_pos3[a]}
                                         + {{2{r_vprod[a][62]}}, r_vprod[a][62:16]});
            r_vel4[a]  <= r_vel3[a];
        end
        assign o_vel[a] = r_vel4[a];
        assign o_pos[a] = r_pos4[a];
    end

endmodule

>>> rtl/core/peu_div.sv
// peu_div: pipelined restoring divider, one quotient bit per stage
// computes floor(num * 65536 / den) for num < den; depends on peu_pkg
module peu_div (
    input  logic        i_clk,
    input  logic [30:0] i_num,
    input  logic [30:0] i_den,
    output logic [15:0] o_quot
);

    localparam int unsigned N = peu_pkg::DIV_STAGES;

    logic [30:0] r_rem [N];
    logic [30:0] r_den [N];
    logic [15:0] r_q   [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [30:0] w_rem_in;
        logic [30:0] w_den_in;
        logic [15:0] w_q_in;
        logic [31:0] w_shift;
        logic [31:0] w_trial;
        logic        w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_q_in   = r_q[s-1];
        end

        assign w_shift = {w_rem_in, 1'b0};
        assign w_ge    = w_shift >= {1'b0, w_den_in};
        assign w_trial = w_shift - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            r_rem[s] <= w_ge ? w_trial[30:0] : w_shift[30:0];
            r_den[s] <= w_den_in;
            r_q[s]   <= {w_q_in[14:0], w_ge};
        end
    end

    assign o_quot = r_q[N-1];

endmodule

>>> rtl/core/peu_blend.sv
// peu_blend: three-stage linear blend of colour and size by age fraction
// no package dependencies
module peu_blend (
    input  logic        i_clk,
    input  logic        i_use_t,
    input  logic [15:0] i_quot,
    input  logic [63:0] i_start_color,
    input  logic [63:0] i_end_color,
    input  logic [15:0] i_start_size,
    input  logic [15:0] i_end_size,
    output logic [63:0] o_color,
    output logic [15:0] o_size
);

    logic [16:0] r_t;
    logic [32:0] r_ps [5];
    logic [32:0] r_pe [5];
    logic [15:0] r_res [5];
    logic [15:0] w_s [5];
    logic [15:0] w_e [5];
    logic [16:0] w_omt;

    assign w_omt = 17'h10000 - r_t;

    for (genvar k = 0; k < 4; k++) begin : g_ch
        assign w_s[k] = i_start_color[63-16*k -: 16];
        assign w_e[k] = i_end_color[63-16*k -: 16];
        assign o_color[63-16*k -: 16] = r_res[k];
    end
    assign w_s[4] = i_start_size;
    assign w_e[4] = i_end_size;
    assign o_size = r_res[4];

    always_ff @(posedge i_clk) begin
        r_t <= i_use_t ? (17'h10000 - {1'b0, i_quot}) : 17'd0;
    end

    for (genvar k = 0; k < 5; k++) begin : g_mul
        logic [33:0] w_sum;
        assign w_sum = {1'b0, r_ps[k]} + {1'b0, r_pe[k]};
        always_ff @(posedge i_clk) begin
            r_ps[k]  <= {17'd0, w_s[k]} * {16'd0, w_omt};
            r_pe[k]  <= {17'd0, w_e[k]} * {16'd0, r_t};
            r_res[k] <= w_sum[31:16];
        end
    end

endmodule

>>> rtl/core/particle_euler_update_core.sv
// particle_euler_update_core: top level of the particle step pipeline
// depends on peu_pkg, peu_kin, peu_div and peu_blend
//
// usage:
//   item in: raise start with i_item; it is taken when start is high and busy
//   low. busy stays low, so an item can enter on every clock.
//   result: o_valid marks o_item for exactly one cycle; the receiver must take
//   it then, there is no back pressure.
//   config: i_cfg_valid/o_cfg_ready write channel, register index and data;
//   o_cfg_ready is always high. write only while no item is in flight.
// path: an accepted item passes the input register, the 16-stage age divider,
//   three blend stages and the output register; o_valid rises with the result.
// throughput: one item per cycle, the divider and all multipliers are fully
//   pipelined.
// reset: synchronous active low i_rst_n clears the valid line and loads the
//   register defaults (time step 1049, everything else zero).
module particle_euler_update_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  peu_pkg::t_in_item   i_item,
    output logic                o_valid,
    output peu_pkg::t_out_item  o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [peu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]         i_cfg_data
);

    localparam int unsigned SIDE_DLY = peu_pkg::DIV_STAGES + 3;
    localparam int unsigned KIN_DLY  = peu_pkg::KIN_DLY;

    // side record carried next to the arithmetic
    typedef struct packed {
        logic               valid;
        logic               live;
        logic signed [31:0] life;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_side;

    // config registers
    logic [30:0]        r_time_step;
    logic signed [31:0] r_grav [3];
    logic [63:0]        r_start_color;
    logic [63:0]        r_end_color;
    logic [15:0]        r_start_size;
    logic [15:0]        r_end_size;

    // input stage
    t_side              r_a;
    logic               r_a_use_t;
    logic [30:0]        r_a_num;
    logic [30:0]        r_a_den;
    logic signed [31:0] w_life_dec;
    logic               w_live;
    logic               w_accept;

    t_side              r_side [SIDE_DLY];
    t_side              n_side [SIDE_DLY];
    logic signed [31:0] r_kv [KIN_DLY][3];
    logic signed [31:0] r_kp [KIN_DLY][3];
    logic               r_use_t [peu_pkg::DIV_STAGES];

    logic signed [31:0] w_kin_vel [3];
    logic signed [31:0] w_kin_pos [3];
    logic signed [31:0] w_vel_in  [3];
    logic signed [31:0] w_pos_in  [3];
    logic [15:0]        w_quot;
    logic [63:0]        w_color;
    logic [15:0]        w_size;

    logic               r_out_valid;
    peu_pkg::t_out_item r_out;
    t_side              w_end;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;

    // config write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= 31'd1049;
            r_grav[0]     <= '0;
            r_grav[1]     <= '0;
            r_grav[2]     <= '0;
            r_start_color <= '0;
            r_end_color   <= '0;
            r_start_size  <= '0;
            r_end_size    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (peu_pkg::t_cfg_idx'(i_cfg_index))
                peu_pkg::CFG_TIME_STEP:   r_time_step   <= i_cfg_data[30:0];
                peu_pkg::CFG_GRAVITY_X:   r_grav[0]     <= i_cfg_data[31:0];
                peu_pkg::CFG_GRAVITY_Y:   r_grav[1]     <= i_cfg_data[31:0];
                peu_pkg::CFG_GRAVITY_Z:   r_grav[2]     <= i_cfg_data[31:0];
                peu_pkg::CFG_START_COLOR: r_start_color <= i_cfg_data;
                peu_pkg::CFG_END_COLOR:   r_end_color   <= i_cfg_data;
                peu_pkg::CFG_START_SIZE:  r_start_size  <= i_cfg_data[15:0];
                peu_pkg::CFG_END_SIZE:    r_end_size    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // life decrement and live decision at the input
    assign w_life_dec = peu_pkg::sat32({{17{i_item.life_in[31]}}, i_item.life_in}
                                       - {18'd0, r_time_step});
    assign w_live = i_item.alive_in && (w_life_dec > 32'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else begin
            r_a.valid <= w_accept;
        end
        r_a.live  <= w_live;
        r_a.life  <= i_item.alive_in ? w_life_dec : i_item.life_in;
        r_a.vel_x <= i_item.vel_x_in;
        r_a.vel_y <= i_item.vel_y_in;
        r_a.vel_z <= i_item.vel_z_in;
        r_a.pos_x <= i_item.pos_x_in;
        r_a.pos_y <= i_item.pos_y_in;
        r_a.pos_z <= i_item.pos_z_in;
        // age fraction only when life is below initial life
        r_a_use_t <= w_live && (i_item.initial_life != 31'd0)
                     && (w_life_dec[30:0] < i_item.initial_life);
        r_a_num   <= w_life_dec[30:0];
        r_a_den   <= i_item.initial_life;
    end

    assign w_vel_in[0] = r_a.vel_x;
    assign w_vel_in[1] = r_a.vel_y;
    assign w_vel_in[2] = r_a.vel_z;
    assign w_pos_in[0] = r_a.pos_x;
    assign w_pos_in[1] = r_a.pos_y;
    assign w_pos_in[2] = r_a.pos_z;

    peu_kin u_kin (
        .i_clk       (i_clk),
        .i_time_step (r_time_step),
        .i_grav      (r_grav),
        .i_vel       (w_vel_in),
        .i_pos       (w_pos_in),
        .o_vel       (w_kin_vel),
        .o_pos       (w_kin_pos)
    );

    peu_div u_div (
        .i_clk  (i_clk),
        .i_num  (r_a_num),
        .i_den  (r_a_den),
        .o_quot (w_quot)
    );

    // flag that travels alongside the divider
    always_ff @(posedge i_clk) begin
        r_use_t[0] <= r_a_use_t;
        for (int s = 1; s < peu_pkg::DIV_STAGES; s++) begin
            r_use_t[s] <= r_use_t[s-1];
        end
    end

    peu_blend u_blend (
        .i_clk         (i_clk),
        .i_use_t       (r_use_t[peu_pkg::DIV_STAGES-1]),
        .i_quot        (w_quot),
        .i_start_color (r_start_color),
        .i_end_color   (r_end_color),
        .i_start_size  (r_start_size),
        .i_end_size    (r_end_size),
        .o_color       (w_color),
        .o_size        (w_size)
    );

    // side line: valid is the only field that needs reset
    always_comb begin
        n_side[0] = r_a;
        for (int s = 1; s < SIDE_DLY; s++) begin
            n_side[s] = r_side[s-1];
        end
        if (!i_rst_n) begin
            for (int s = 0; s < SIDE_DLY; s++) begin
                n_side[s].valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= n_side;
    end

    // kinematics results wait for the age fraction path
    always_ff @(posedge i_clk) begin
        r_kv[0] <= w_kin_vel;
        r_kp[0] <= w_kin_pos;
        for (int s = 1; s < KIN_DLY; s++) begin
            r_kv[s] <= r_kv[s-1];
            r_kp[s] <= r_kp[s-1];
        end
    end

    assign w_end = r_side[SIDE_DLY-1];

    // output register: dead or disabled items keep their input velocity and position and get zero colour and size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_end.valid;
        end
        r_out.alive_out <= w_end.live;
        r_out.life_out  <= w_end.life;
        if (w_end.live) begin
            r_out.vel_x_out <= r_kv[KIN_DLY-1][0];
            r_out.vel_y_out <= r_kv[KIN_DLY-1][1];
            r_out.vel_z_out <= r_kv[KIN_DLY-1][2];
            r_out.pos_x_out <= r_kp[KIN_DLY-1][0];
            r_out.pos_y_out <= r_kp[KIN_DLY-1][1];
            r_out.pos_z_out <= r_kp[KIN_DLY-1][2];
            r_out.color_out <= w_color;
            r_out.size_out  <= w_size;
        end else begin
            r_out.vel_x_out <= w_end.vel_x;
            r_out.vel_y_out <= w_end.vel_y;
            r_out.vel_z_out <= w_end.vel_z;
            r_out.pos_x_out <= w_end.pos_x;
            r_out.pos_y_out <= w_end.pos_y;
            r_out.pos_z_out <= w_end.pos_z;
            r_out.color_out <= '0;
            r_out.size_out  <= '0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
